// File: hw/rtl/utf8dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8dec_pkg
// shared constants, types and helpers of the streaming utf-8 decoder
// ----------------------------------------------------------------------------
package utf8dec_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned PEND_W  = 2;
  localparam int unsigned CNT_W   = 3;

  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_CODE  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_CODE  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_CODE  = 8'hF0;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_CODE   = 8'h80;
  localparam logic [7:0] ASCII_LIMIT = 8'h80;

  localparam logic [CP_W-1:0] MIN_CP2 = CP_W'(32'h80);
  localparam logic [CP_W-1:0] MIN_CP3 = CP_W'(32'h800);
  localparam logic [CP_W-1:0] MIN_CP4 = CP_W'(32'h10000);
  localparam logic [CP_W-1:0] MAX_CP  = CP_W'(32'h10FFFF);

  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  // last result of a burst, preceded by a run of one-byte error results
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             is_valid;
    logic [LEN_W-1:0] consumed_bytes;
  } final_res_t;

  // bytes of an open sequence received so far, bounded to 1..3
  function automatic logic [PEND_W-1:0] bytes_received(input logic [LEN_W-1:0] elen,
                                                       input logic [PEND_W-1:0] pend);
    logic [LEN_W-1:0] r;
    begin
      if (elen > {1'b0, pend}) begin
        r = elen - {1'b0, pend};
      end else begin
        r = LEN_ONE;
      end
      if (r > LEN_THREE) begin
        r = LEN_THREE;
      end
      bytes_received = r[PEND_W-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/utf8_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// streaming utf-8 decoder: one byte in, zero to four decoded results out
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | byte_value, end_of_buffer
//  out_    | output    | out_valid/out_stall | code_point, is_valid,
//          |           |                   | consumed_bytes, run_last
//
//  a byte is decoded in the cycle it is accepted; its results sit in the
//  result register from the next cycle and leave one per unstalled cycle
//  a byte causing k results holds the input until its last result is taken
//  (the single result register drains them); else a byte per unstalled cycle
//  the next byte is taken in the cycle the last result of a burst is taken
//  rst_n is synchronous and active low; it closes any open sequence
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core
  import utf8dec_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte_value,
  input  logic             in_end_of_buffer,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CP_W-1:0]  out_code_point,
  output logic             out_is_valid,
  output logic [LEN_W-1:0] out_consumed_bytes,
  output logic             out_run_last
);

  // sequence state
  logic [CP_W-1:0]   pv_r, pv_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [LEN_W-1:0]  elen_r, elen_nxt;

  // result burst
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              has_fin_r, has_fin_nxt;
  final_res_t        fin_r, fin_nxt;

  logic              in_acc;
  logic              out_acc;
  logic [7:0]        b;
  logic              eob;
  logic              is_cont;
  logic              as_lead;
  logic [PEND_W-1:0] n_err;
  logic [CP_W-1:0]   cp_ext;
  logic [PEND_W-1:0] pend_dec;
  logic              ok;
  final_res_t        err_res;

  assign b        = in_byte_value;
  assign eob      = in_end_of_buffer;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (cnt_r > CNT_W'(1)) || ((cnt_r == CNT_W'(1)) && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign is_cont  = (b & CONT_MASK) == CONT_CODE;
  assign cp_ext   = {pv_r[CP_W-7:0], b[5:0]};
  assign pend_dec = pend_r - PEND_W'(1);
  assign err_res  = '{code_point: '0, is_valid: 1'b0, consumed_bytes: LEN_ONE};

  always_comb begin
    case (elen_r)
      LEN_TWO:   ok = cp_ext >= MIN_CP2;
      LEN_THREE: ok = cp_ext >= MIN_CP3;
      default:   ok = (cp_ext >= MIN_CP4) && (cp_ext <= MAX_CP);
    endcase
  end

  always_comb begin
    pv_nxt      = pv_r;
    pend_nxt    = pend_r;
    elen_nxt    = elen_r;
    n_err       = '0;
    has_fin_nxt = 1'b0;
    fin_nxt     = err_res;
    as_lead     = 1'b1;

    if (pend_r != '0) begin
      if (is_cont) begin
        as_lead = 1'b0;
        if (pend_dec == '0) begin
          has_fin_nxt = 1'b1;
          fin_nxt     = '{code_point: cp_ext, is_valid: ok, consumed_bytes: elen_r};
          pv_nxt      = '0;
          pend_nxt    = '0;
          elen_nxt    = LEN_NONE;
        end else if (eob) begin
          n_err    = bytes_received(elen_r, pend_dec);
          pv_nxt   = '0;
          pend_nxt = '0;
          elen_nxt = LEN_NONE;
        end else begin
          pv_nxt   = cp_ext;
          pend_nxt = pend_dec;
        end
      end else begin
        // missing continuation
        n_err    = bytes_received(elen_r, pend_r);
        pv_nxt   = '0;
        pend_nxt = '0;
        elen_nxt = LEN_NONE;
      end
    end

    if (as_lead) begin
      if (b < ASCII_LIMIT) begin
        has_fin_nxt = 1'b1;
        fin_nxt     = '{code_point: CP_W'(b), is_valid: 1'b1, consumed_bytes: LEN_ONE};
      end else if ((b & LEAD2_MASK) == LEAD2_CODE ||
                   (b & LEAD3_MASK) == LEAD3_CODE ||
                   (b & LEAD4_MASK) == LEAD4_CODE) begin
        if (eob) begin
          has_fin_nxt = 1'b1;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
          pv_nxt   = CP_W'(b[4:0]);
          elen_nxt = LEN_TWO;
          pend_nxt = PEND_W'(1);
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
          pv_nxt   = CP_W'(b[3:0]);
          elen_nxt = LEN_THREE;
          pend_nxt = PEND_W'(2);
        end else begin
          pv_nxt   = CP_W'(b[2:0]);
          elen_nxt = LEN_FOUR;
          pend_nxt = PEND_W'(3);
        end
      end else begin
        // bad lead
        has_fin_nxt = 1'b1;
      end
    end

    cnt_nxt = CNT_W'(n_err) + CNT_W'(has_fin_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= '0;
      pend_r <= '0;
      elen_r <= LEN_NONE;
      cnt_r  <= '0;
    end else begin
      if (in_acc) begin
        pv_r   <= pv_nxt;
        pend_r <= pend_nxt;
        elen_r <= elen_nxt;
        cnt_r  <= cnt_nxt;
      end else if (out_acc) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      has_fin_r <= has_fin_nxt;
      fin_r     <= fin_nxt;
    end
  end

  // error results come first, the final result last
  assign out_valid    = cnt_r != '0;
  assign out_run_last = cnt_r == CNT_W'(1);
  always_comb begin
    if (out_run_last && has_fin_r) begin
      out_code_point     = fin_r.code_point;
      out_is_valid       = fin_r.is_valid;
      out_consumed_bytes = fin_r.consumed_bytes;
    end else begin
      out_code_point     = err_res.code_point;
      out_is_valid       = err_res.is_valid;
      out_consumed_bytes = err_res.consumed_bytes;
    end
  end

  // open sequence is always longer than what is still missing
  a_pend_len: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != '0 |-> (elen_r > {1'b0, pend_r}) && (elen_r >= LEN_TWO))
    else $error("open sequence length inconsistent");

  // closed sequence holds no stale bits
  a_closed: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == '0 |-> (elen_r == LEN_NONE) && (pv_r == '0))
    else $error("closed sequence not cleared");

  // a burst never exceeds four results
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(4))
    else $error("result burst too long");

  // a taken result without a new item shortens the burst by one
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !in_acc) |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("burst count did not drain");

  // an item is only taken when the burst is empty or leaves now
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cnt_r == '0) || (out_acc && out_run_last))
    else $error("item taken over a pending burst");

endmodule
